>>> rtl/s2c_pkg.sv
package s2c_pkg;

    // Field widths
    localparam int DIST_W = 16;
    localparam int ANG_W  = 18;
    localparam int OUT_W  = 17;

    // Q30 trig word and 32-bit binary angle (one turn = 2^32)
    localparam int Q_W        = 32;
    localparam int MAX_STAGES = 24;

    // Angle reduction: 92160 = 2^11 * 45, so the binary angle is
    // floor((ang * 2^21 + 22) / 45) with ang in [0, 92160)
    localparam int TURN_UNITS  = 92160;
    localparam int RED_W       = 17;
    localparam int TURN_DIV    = 45;
    localparam int FRAC_BIAS   = 22;
    localparam int FRAC_W      = 21;
    localparam int QUOT_W      = 11;
    localparam int REM_W       = 6;
    localparam int RECIP_M     = 372828;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 24;
    localparam int ANGLE_LAT   = 3;

    localparam logic signed [Q_W-1:0] GAIN_Q30 = 32'sh26DD_3B6A;
    localparam logic signed [Q_W-1:0] ONE_Q30  = 32'sh4000_0000;

    localparam logic [OUT_W-1:0] OUT_MAX = 17'd65535;

    localparam logic signed [Q_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
        32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
        32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
        32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D,
        32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518,
        32'sh0000_028C, 32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051
    };

    typedef logic [FRAC_W-1:0] frac_t;
    typedef frac_t frac_tab_t [2**REM_W];

    // Low binary-angle bits for each remainder of the division by 45
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t tab;
        for (int i = 0; i < 2**REM_W; i++) begin
            if (i < TURN_DIV) begin
                tab[i] = FRAC_W'(((longint'(i) << FRAC_W) + FRAC_BIAS) / TURN_DIV);
            end else begin
                tab[i] = '0;
            end
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

    // Rotation request: residual angle and the half-turn flag
    typedef struct packed {
        logic signed [Q_W-1:0] z;
        logic                  flip;
    } rot_t;

    // Clamped Q30 cosine and sine
    typedef struct packed {
        logic signed [Q_W-1:0] cosv;
        logic signed [Q_W-1:0] sinv;
    } trig_t;

endpackage

>>> rtl/s2c_angle.sv
module s2c_angle
    import s2c_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    rot_valid,
    output rot_t                    rot
);

    localparam logic signed [19:0] TURN_S = 20'(TURN_UNITS);

    logic signed [19:0]        a_ext;
    logic signed [19:0]        a_red;
    logic [RED_W-1:0]          ang1_next;
    logic [RED_W-1:0]          ang1_reg;
    logic                      vld1_reg;
    logic [RED_W+RECIP_W-1:0]  quot_prod;
    logic [QUOT_W-1:0]         quot2_next;
    logic [QUOT_W-1:0]         quot2_reg;
    logic [RED_W-1:0]          ang2_reg;
    logic                      vld2_reg;
    logic [RED_W-1:0]          rem_full;
    logic [Q_W-1:0]            bang;
    logic                      flip;
    rot_t                      rot_next;
    rot_t                      rot_reg;
    logic                      vld3_reg;

    // Stage 1: wrap into [0, 360) degrees
    always_comb
    begin
        a_ext = 20'(angle);
        if (a_ext >= TURN_S)
        begin
            a_red = a_ext - TURN_S;
        end
        else if (a_ext >= 0)
        begin
            a_red = a_ext;
        end
        else if (a_ext >= -TURN_S)
        begin
            a_red = a_ext + TURN_S;
        end
        else
        begin
            a_red = a_ext + (TURN_S <<< 1);
        end
        ang1_next = a_red[RED_W-1:0];
    end

    // Stage 2: quotient by 45 through the reciprocal (exact below 92160)
    assign quot_prod  = (RED_W+RECIP_W)'(ang1_reg) * (RED_W+RECIP_W)'(RECIP_M);
    assign quot2_next = quot_prod[RECIP_SHIFT +: QUOT_W];

    // Stage 3: remainder picks the low binary-angle bits; fold the left half-plane
    assign rem_full = ang2_reg - RED_W'(RED_W'(quot2_reg) * RED_W'(TURN_DIV));
    assign bang     = {quot2_reg, FRAC_TAB[rem_full[REM_W-1:0]]};
    assign flip     = bang[Q_W-1] ^ bang[Q_W-2];

    always_comb
    begin
        rot_next.z    = signed'(bang ^ {flip, {(Q_W-1){1'b0}}});
        rot_next.flip = flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ang1_reg  <= ang1_next;
        quot2_reg <= quot2_next;
        ang2_reg  <= ang1_reg;
        rot_reg   <= rot_next;
    end

    assign rot_valid = vld3_reg;
    assign rot       = rot_reg;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (rem_full < RED_W'(TURN_DIV)))
        else $error("angle remainder out of range");

    a_rot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid |-> ((rot.z >= -ONE_Q30) && (rot.z < ONE_Q30)))
        else $error("folded angle outside +/-90 degrees");
`endif

endmodule

>>> rtl/s2c_cordic.sv
module s2c_cordic
    import s2c_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rot_valid,
    input  rot_t  rot,
    output logic  trig_valid,
    output trig_t trig
);

    logic signed [Q_W-1:0] x_reg    [STAGES];
    logic signed [Q_W-1:0] y_reg    [STAGES];
    logic signed [Q_W-1:0] z_reg    [STAGES];
    logic                  flip_reg [STAGES];
    logic                  vld_reg  [STAGES];

    logic signed [Q_W-1:0] cos_raw;
    logic signed [Q_W-1:0] sin_raw;
    trig_t                 trig_next;
    trig_t                 trig_reg;
    logic                  trig_vld_reg;

    function automatic logic signed [Q_W-1:0] clamp_q30(input logic signed [Q_W-1:0] v);
        if (v > ONE_Q30)
        begin
            return ONE_Q30;
        end
        else if (v < -ONE_Q30)
        begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [Q_W-1:0] x_cur;
        logic signed [Q_W-1:0] y_cur;
        logic signed [Q_W-1:0] z_cur;
        logic                  flip_cur;
        logic                  vld_cur;
        logic signed [Q_W-1:0] x_next;
        logic signed [Q_W-1:0] y_next;
        logic signed [Q_W-1:0] z_next;

        if (i == 0)
        begin : g_first
            assign x_cur    = GAIN_Q30;
            assign y_cur    = '0;
            assign z_cur    = rot.z;
            assign flip_cur = rot.flip;
            assign vld_cur  = rot_valid;
        end
        else
        begin : g_rest
            assign x_cur    = x_reg[i-1];
            assign y_cur    = y_reg[i-1];
            assign z_cur    = z_reg[i-1];
            assign flip_cur = flip_reg[i-1];
            assign vld_cur  = vld_reg[i-1];
        end

        // Rotate toward zero residual
        always_comb
        begin
            if (!z_cur[Q_W-1])
            begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - ATAN_TAB[i];
            end
            else
            begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]    <= x_next;
            y_reg[i]    <= y_next;
            z_reg[i]    <= z_next;
            flip_reg[i] <= flip_cur;
        end
    end

    // Undo the half-turn fold, then clamp to +/-1.0
    assign cos_raw = flip_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
    assign sin_raw = flip_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];

    always_comb
    begin
        trig_next.cosv = clamp_q30(cos_raw);
        trig_next.sinv = clamp_q30(sin_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_vld_reg <= 1'b0;
        end
        else
        begin
            trig_vld_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign trig_valid = trig_vld_reg;
    assign trig       = trig_reg;

endmodule

>>> rtl/s2c_scale.sv
module s2c_scale
    import s2c_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    trig_valid,
    input  logic [DIST_W-1:0]       distance,
    input  trig_t                   pan_trig,
    input  trig_t                   tilt_trig,
    output logic                    done,
    output logic signed [OUT_W-1:0] pos_x,
    output logic signed [OUT_W-1:0] pos_y,
    output logic signed [OUT_W-1:0] pos_z
);

    localparam int MAG_W   = Q_W - 1;
    localparam int DPROD_W = DIST_W + MAG_W;
    localparam int REACH_W = DIST_W + 16;
    localparam int XPROD_W = REACH_W + MAG_W;

    logic [Q_W-1:0]           ct_abs;
    logic [Q_W-1:0]           st_abs;
    logic [Q_W-1:0]           cp_abs;
    logic [Q_W-1:0]           sp_abs;
    logic [DPROD_W-1:0]       reach_prod;
    logic [DPROD_W-1:0]       zd_prod;
    logic [DPROD_W-1:0]       reach_rnd;
    logic [DPROD_W-1:0]       zd_rnd;

    logic [REACH_W-1:0]       reach_mag_reg;
    logic                     reach_neg_reg;
    logic [OUT_W-1:0]         z1_mag_reg;
    logic                     z1_neg_reg;
    logic [MAG_W-1:0]         cp_mag_reg;
    logic                     cp_neg_reg;
    logic [MAG_W-1:0]         sp_mag_reg;
    logic                     sp_neg_reg;
    logic                     vld1_reg;

    logic [XPROD_W-1:0]       px_next;
    logic [XPROD_W-1:0]       py_next;
    logic [XPROD_W-1:0]       px_reg;
    logic [XPROD_W-1:0]       py_reg;
    logic                     x_neg_reg;
    logic                     y_neg_reg;
    logic [OUT_W-1:0]         z2_mag_reg;
    logic                     z2_neg_reg;
    logic                     vld2_reg;

    logic [XPROD_W-1:0]       px_rnd;
    logic [XPROD_W-1:0]       py_rnd;
    logic signed [OUT_W-1:0]  pos_x_next;
    logic signed [OUT_W-1:0]  pos_y_next;
    logic signed [OUT_W-1:0]  pos_z_next;
    logic signed [OUT_W-1:0]  pos_x_reg;
    logic signed [OUT_W-1:0]  pos_y_reg;
    logic signed [OUT_W-1:0]  pos_z_reg;
    logic                     done_reg;

    function automatic logic signed [OUT_W-1:0] sat_sign(input logic [OUT_W-1:0] mag,
                                                         input logic            neg);
        logic [OUT_W-1:0] m;
        m = (mag > OUT_MAX) ? OUT_MAX : mag;
        return neg ? -signed'(m) : signed'(m);
    endfunction

    assign ct_abs = tilt_trig.cosv[Q_W-1] ? Q_W'(-tilt_trig.cosv) : Q_W'(tilt_trig.cosv);
    assign st_abs = tilt_trig.sinv[Q_W-1] ? Q_W'(-tilt_trig.sinv) : Q_W'(tilt_trig.sinv);
    assign cp_abs = pan_trig.cosv[Q_W-1]  ? Q_W'(-pan_trig.cosv)  : Q_W'(pan_trig.cosv);
    assign sp_abs = pan_trig.sinv[Q_W-1]  ? Q_W'(-pan_trig.sinv)  : Q_W'(pan_trig.sinv);

    // Stage 1: reach = d*cos(tilt) rounded to Q16, z = d*sin(tilt) rounded to integer
    assign reach_prod = DPROD_W'(distance) * DPROD_W'(ct_abs[MAG_W-1:0]);
    assign zd_prod    = DPROD_W'(distance) * DPROD_W'(st_abs[MAG_W-1:0]);
    assign reach_rnd  = (reach_prod + (DPROD_W'(1) << 13)) >> 14;
    assign zd_rnd     = (zd_prod + (DPROD_W'(1) << 29)) >> 30;

    // Stage 2: reach times cos/sin(pan), full Q46 products
    assign px_next = XPROD_W'(reach_mag_reg) * XPROD_W'(cp_mag_reg);
    assign py_next = XPROD_W'(reach_mag_reg) * XPROD_W'(sp_mag_reg);

    // Stage 3: round half away from zero, saturate, apply sign
    assign px_rnd = (px_reg + (XPROD_W'(1) << 45)) >> 46;
    assign py_rnd = (py_reg + (XPROD_W'(1) << 45)) >> 46;

    assign pos_x_next = sat_sign(px_rnd[OUT_W-1:0], x_neg_reg);
    assign pos_y_next = sat_sign(py_rnd[OUT_W-1:0], y_neg_reg);
    assign pos_z_next = sat_sign(z2_mag_reg, z2_neg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= trig_valid;
            vld2_reg <= vld1_reg;
            done_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        reach_mag_reg <= reach_rnd[REACH_W-1:0];
        reach_neg_reg <= tilt_trig.cosv[Q_W-1];
        z1_mag_reg    <= zd_rnd[OUT_W-1:0];
        z1_neg_reg    <= tilt_trig.sinv[Q_W-1];
        cp_mag_reg    <= cp_abs[MAG_W-1:0];
        cp_neg_reg    <= pan_trig.cosv[Q_W-1];
        sp_mag_reg    <= sp_abs[MAG_W-1:0];
        sp_neg_reg    <= pan_trig.sinv[Q_W-1];

        px_reg        <= px_next;
        py_reg        <= py_next;
        x_neg_reg     <= reach_neg_reg ^ cp_neg_reg;
        y_neg_reg     <= reach_neg_reg ^ sp_neg_reg;
        z2_mag_reg    <= z1_mag_reg;
        z2_neg_reg    <= z1_neg_reg;

        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        pos_z_reg     <= pos_z_next;
    end

    assign done  = done_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;

`ifndef SYNTHESIS
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((pos_x != -(OUT_W'(OUT_MAX) + 1'b1)) && (pos_y != -(OUT_W'(OUT_MAX) + 1'b1))
                  && (pos_z != -(OUT_W'(OUT_MAX) + 1'b1))))
        else $error("coordinate escaped saturation");
`endif

endmodule

>>> rtl/spherical_to_cartesian.sv
// Spherical to Cartesian converter for scanner samples. Pulse start with a distance and
// pan/tilt angles in 1/256 degree; the block returns x = d*cos(tilt)*cos(pan),
// y = d*cos(tilt)*sin(pan) and z = d*sin(tilt), rounded half away from zero to
// distance units and saturated to +/-65535. The datapath is a straight pipeline: three
// stages of angle wrap and binary-angle conversion, CORDIC_STAGES rotation stages (at
// most 24; two rotators in parallel, one per angle) plus a fold/clamp stage, and three
// multiply, round and saturate stages. A new word is taken every clock cycle, so busy
// stays low; the result appears with done high for one cycle, in the order the words
// came in. The receiver cannot stall this block: latch pos_x, pos_y and pos_z whenever
// done is high. Only the low DIST_BITS bits of distance take part (all 16 when
// DIST_BITS is 16 or more), and CORDIC_STAGES sets both the accuracy and the latency.
module spherical_to_cartesian
    import s2c_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int DIST_BITS     = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DIST_W-1:0]       distance,
    input  logic signed [ANG_W-1:0] pan_angle,
    input  logic signed [ANG_W-1:0] tilt_angle,
    output logic                    done,
    output logic signed [OUT_W-1:0] pos_x,
    output logic signed [OUT_W-1:0] pos_y,
    output logic signed [OUT_W-1:0] pos_z
);

    // Rotation steps actually built (the arctangent table has 24 entries)
    localparam int NSTG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int DW   = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;
    // Distance rides alongside the angle and rotation stages
    localparam int DLY  = ANGLE_LAT + NSTG + 1;

    logic [DIST_W-1:0] dist_mask;
    logic [DIST_W-1:0] dist_dly_reg [DLY];

    logic  pan_rot_vld;
    logic  tilt_rot_vld;
    rot_t  pan_rot;
    rot_t  tilt_rot;
    logic  pan_trig_vld;
    logic  tilt_trig_vld;
    trig_t pan_trig;
    trig_t tilt_trig;

    // No backpressure anywhere in the pipe
    assign busy = 1'b0;

    assign dist_mask = {DIST_W{1'b1}} >> (DIST_W - DW);

    // Hold distance in step with the angle path
    always_ff @(posedge clk)
    begin
        dist_dly_reg[0] <= distance & dist_mask;
        for (int k = 1; k < DLY; k++)
        begin
            dist_dly_reg[k] <= dist_dly_reg[k-1];
        end
    end

    s2c_angle u_pan_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (start),
        .angle     (pan_angle),
        .rot_valid (pan_rot_vld),
        .rot       (pan_rot)
    );

    s2c_angle u_tilt_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (start),
        .angle     (tilt_angle),
        .rot_valid (tilt_rot_vld),
        .rot       (tilt_rot)
    );

    s2c_cordic #(
        .STAGES (NSTG)
    ) u_pan_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .rot_valid  (pan_rot_vld),
        .rot        (pan_rot),
        .trig_valid (pan_trig_vld),
        .trig       (pan_trig)
    );

    s2c_cordic #(
        .STAGES (NSTG)
    ) u_tilt_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .rot_valid  (tilt_rot_vld),
        .rot        (tilt_rot),
        .trig_valid (tilt_trig_vld),
        .trig       (tilt_trig)
    );

    // Both rotators march in lockstep; advance the scaler only on a full pair
    s2c_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_valid (pan_trig_vld & tilt_trig_vld),
        .distance   (dist_dly_reg[DLY-1]),
        .pan_trig   (pan_trig),
        .tilt_trig  (tilt_trig),
        .done       (done),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z)
    );

`ifndef SYNTHESIS
    a_rotators_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (pan_trig_vld == tilt_trig_vld) && (pan_rot_vld == tilt_rot_vld))
        else $error("pan and tilt paths out of step");
`endif

endmodule
